### src/olid_pkg.sv
// Shared types, constants and helpers for the ordered list block.
// No dependencies; imported by every module of the block.
package olid_pkg;

    // Store geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the item interfaces
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;

    // Operation codes; the two unused codes behave as a query
    localparam logic [OP_W-1:0] OP_INS_FRONT = OP_W'(0);
    localparam logic [OP_W-1:0] OP_INS_BACK  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_INS_POS   = OP_W'(2);
    localparam logic [OP_W-1:0] OP_DEL_FRONT = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DEL_BACK  = OP_W'(4);
    localparam logic [OP_W-1:0] OP_QUERY     = OP_W'(5);

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_POS,
        STAT_FULL,
        STAT_EMPTY
    } olid_status_t;

    typedef logic [IDX_W-1:0] olid_idx_t;
    typedef logic [CNT_W-1:0] olid_cnt_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } olid_in_t;

    typedef struct packed {
        olid_status_t              status;
        logic [COUNT_W-1:0]        element_count;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
    } olid_out_t;

    // Port requests to the node store
    typedef struct packed {
        logic                      link_we;
        olid_idx_t                 link_waddr;
        olid_idx_t                 link_wdata;
        olid_idx_t                 link_raddr;
        logic                      val_we;
        olid_idx_t                 val_waddr;
        logic signed [VALUE_W-1:0] val_wdata;
        olid_idx_t                 val_raddr;
    } olid_mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_HEAD,
        ST_LINK2,
        ST_VREAD,
        ST_DONE
    } olid_state_t;

    typedef enum logic [2:0] {
        ACT_QUERY,
        ACT_REJECT,
        ACT_INS_FRONT,
        ACT_INS_BACK,
        ACT_INS_MID,
        ACT_CLEAR,
        ACT_DEL_FRONT,
        ACT_DEL_BACK
    } olid_act_t;

    // Lowest-numbered free node
    function automatic olid_idx_t lowest_free(input logic [CAPACITY-1:0] map);
        olid_idx_t idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (map[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### src/ordered_list_insert_delete.sv
// Queries, rejects, clears and inserts into an empty list go straight to the result; insert front/back
// adds a second link write; delete front reads the new head and then its value; insert at a position
// and delete back walk the chain at one link-memory read per cycle.
// One item at a time: the next item is taken once the result is in the output register.
// Reset (aresetn low, synchronous) empties the list without a memory clearing pass.
module ordered_list_insert_delete
    import olid_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  olid_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output olid_out_t m_payload
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    olid_state_t               state_reg, state_next;
    olid_idx_t                 head_reg, head_next;
    olid_idx_t                 tail_reg, tail_next;
    olid_cnt_t                 length_reg, length_next;
    logic [CAPACITY-1:0]       free_map_reg, free_map_next;
    logic signed [VALUE_W-1:0] front_reg, front_next;
    logic signed [VALUE_W-1:0] back_reg, back_next;
    olid_status_t              status_reg, status_next;
    olid_idx_t                 cur_reg, cur_next;
    olid_idx_t                 n_reg, n_next;
    logic [POS_W-1:0]          remaining_reg, remaining_next;
    logic                      del_mode_reg, del_mode_next;
    logic                      vread_front_reg, vread_front_next;
    olid_idx_t                 link2_addr_reg, link2_addr_next;
    olid_idx_t                 link2_data_reg, link2_data_next;
    olid_out_t                 out_reg, out_next;
    logic                      m_valid_reg, m_valid_next;

    olid_mem_req_t             req;
    olid_idx_t                 link_rdata;
    logic signed [VALUE_W-1:0] val_rdata;

    olid_act_t                 act;
    olid_status_t              act_status;
    olid_idx_t                 free_idx;
    logic                      accept;
    logic                      full;
    logic                      is_insert;
    logic                      is_delete;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          len_p1;
    logic                      walk_end;
    logic                      out_free;

    olid_store u_store (
        .aclk       (aclk),
        .req        (req),
        .link_rdata (link_rdata),
        .val_rdata  (val_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign free_idx  = lowest_free(free_map_reg);
    assign full      = (length_reg >= CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(s_payload.position);
    assign len_p1    = CMP_W'(length_reg) + CMP_W'(1);
    assign walk_end  = del_mode_reg ? (link_rdata == tail_reg) : (remaining_reg == '0);

    // Decode the incoming item into one action
    always_comb begin
        is_insert  = (s_payload.op == OP_INS_FRONT) || (s_payload.op == OP_INS_BACK) ||
                     (s_payload.op == OP_INS_POS);
        is_delete  = (s_payload.op == OP_DEL_FRONT) || (s_payload.op == OP_DEL_BACK);
        act_status = STAT_OK;
        priority if ((s_payload.op == OP_INS_POS) &&
                     ((pos_ext == '0) || (pos_ext > len_p1))) begin
            act        = ACT_REJECT;
            act_status = STAT_BAD_POS;
        end else if (is_insert && full) begin
            act        = ACT_REJECT;
            act_status = STAT_FULL;
        end else if (is_delete && (length_reg == '0)) begin
            act        = ACT_REJECT;
            act_status = STAT_EMPTY;
        end else if ((s_payload.op == OP_INS_FRONT) ||
                     ((s_payload.op == OP_INS_POS) && (pos_ext == CMP_W'(1)))) begin
            act = ACT_INS_FRONT;
        end else if ((s_payload.op == OP_INS_BACK) ||
                     ((s_payload.op == OP_INS_POS) && (pos_ext == len_p1))) begin
            act = ACT_INS_BACK;
        end else if (s_payload.op == OP_INS_POS) begin
            act = ACT_INS_MID;
        end else if (is_delete && (length_reg == CNT_W'(1))) begin
            act = ACT_CLEAR;
        end else if (s_payload.op == OP_DEL_FRONT) begin
            act = ACT_DEL_FRONT;
        end else if (s_payload.op == OP_DEL_BACK) begin
            act = ACT_DEL_BACK;
        end else begin
            act = ACT_QUERY;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (act)
                        ACT_INS_FRONT,
                        ACT_INS_BACK:  state_next = (length_reg == '0) ? ST_DONE : ST_LINK2;
                        ACT_INS_MID,
                        ACT_DEL_BACK:  state_next = ST_WALK;
                        ACT_DEL_FRONT: state_next = ST_HEAD;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_end) begin
                    state_next = del_mode_reg ? ST_VREAD : ST_LINK2;
                end
            end
            ST_HEAD:  state_next = ST_VREAD;
            ST_LINK2: state_next = ST_DONE;
            ST_VREAD: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory requests and result
    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        length_next      = length_reg;
        free_map_next    = free_map_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        status_next      = status_reg;
        cur_next         = cur_reg;
        n_next           = n_reg;
        remaining_next   = remaining_reg;
        del_mode_next    = del_mode_reg;
        vread_front_next = vread_front_reg;
        link2_addr_next  = link2_addr_reg;
        link2_data_next  = link2_data_reg;
        out_next         = out_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        req            = '0;
        req.link_raddr = head_reg;
        req.val_raddr  = cur_reg;
        req.val_waddr  = free_idx;
        req.val_wdata  = s_payload.value;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next = act_status;
                    n_next      = free_idx;
                    unique case (act)
                        // New node at the front of the chain
                        ACT_INS_FRONT: begin
                            req.val_we              = 1'b1;
                            free_map_next[free_idx] = 1'b0;
                            length_next             = length_reg + CNT_W'(1);
                            front_next              = s_payload.value;
                            head_next               = free_idx;
                            req.link_we             = 1'b1;
                            req.link_waddr          = free_idx;
                            if (length_reg == '0) begin
                                tail_next      = free_idx;
                                back_next      = s_payload.value;
                                req.link_wdata = free_idx;
                            end else begin
                                req.link_wdata  = head_reg;
                                link2_addr_next = tail_reg;
                                link2_data_next = free_idx;
                            end
                        end
                        // New node at the back of the chain
                        ACT_INS_BACK: begin
                            req.val_we              = 1'b1;
                            free_map_next[free_idx] = 1'b0;
                            length_next             = length_reg + CNT_W'(1);
                            back_next               = s_payload.value;
                            tail_next               = free_idx;
                            req.link_we             = 1'b1;
                            req.link_wdata          = free_idx;
                            if (length_reg == '0) begin
                                head_next      = free_idx;
                                front_next     = s_payload.value;
                                req.link_waddr = free_idx;
                            end else begin
                                req.link_waddr  = tail_reg;
                                link2_addr_next = free_idx;
                                link2_data_next = head_reg;
                            end
                        end
                        // Store the value, then walk to the predecessor
                        ACT_INS_MID: begin
                            req.val_we              = 1'b1;
                            free_map_next[free_idx] = 1'b0;
                            length_next             = length_reg + CNT_W'(1);
                            cur_next                = head_reg;
                            remaining_next          = s_payload.position - POS_W'(2);
                            del_mode_next           = 1'b0;
                        end
                        ACT_CLEAR: begin
                            free_map_next[head_reg] = 1'b1;
                            head_next               = '0;
                            tail_next               = '0;
                            length_next             = '0;
                            front_next              = '0;
                            back_next               = '0;
                        end
                        // Read the successor of the head
                        ACT_DEL_FRONT: begin
                            free_map_next[head_reg] = 1'b1;
                            length_next             = length_reg - CNT_W'(1);
                            vread_front_next        = 1'b1;
                        end
                        // Walk until the node that links to the tail
                        ACT_DEL_BACK: begin
                            free_map_next[tail_reg] = 1'b1;
                            length_next             = length_reg - CNT_W'(1);
                            cur_next                = head_reg;
                            del_mode_next           = 1'b1;
                            vread_front_next        = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // One link read per cycle; read data is the link of cur_reg
            ST_WALK: begin
                if (walk_end) begin
                    req.link_we = 1'b1;
                    if (del_mode_reg) begin
                        tail_next      = cur_reg;
                        req.link_waddr = cur_reg;
                        req.link_wdata = head_reg;
                        req.val_raddr  = cur_reg;
                    end else begin
                        req.link_waddr  = n_reg;
                        req.link_wdata  = link_rdata;
                        link2_addr_next = cur_reg;
                        link2_data_next = n_reg;
                    end
                end else begin
                    cur_next       = link_rdata;
                    req.link_raddr = link_rdata;
                    if (!del_mode_reg) begin
                        remaining_next = remaining_reg - POS_W'(1);
                    end
                end
            end
            // New head arrives; close the ring and fetch its value
            ST_HEAD: begin
                head_next      = link_rdata;
                req.link_we    = 1'b1;
                req.link_waddr = tail_reg;
                req.link_wdata = link_rdata;
                req.val_raddr  = link_rdata;
            end
            ST_LINK2: begin
                req.link_we    = 1'b1;
                req.link_waddr = link2_addr_reg;
                req.link_wdata = link2_data_reg;
            end
            ST_VREAD: begin
                if (vread_front_reg) begin
                    front_next = val_rdata;
                end else begin
                    back_next = val_rdata;
                end
            end
            // Load the result once the output register is free
            ST_DONE: begin
                if (out_free) begin
                    out_next.status        = status_reg;
                    out_next.element_count = COUNT_W'(length_reg);
                    out_next.front_value   = front_reg;
                    out_next.back_value    = back_reg;
                    m_valid_next           = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            length_reg   <= '0;
            free_map_reg <= '1;
            front_reg    <= '0;
            back_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            length_reg   <= length_next;
            free_map_reg <= free_map_next;
            front_reg    <= front_next;
            back_reg     <= back_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge aclk) begin
        status_reg      <= status_next;
        cur_reg         <= cur_next;
        n_reg           <= n_next;
        remaining_reg   <= remaining_next;
        del_mode_reg    <= del_mode_next;
        vread_front_reg <= vread_front_next;
        link2_addr_reg  <= link2_addr_next;
        link2_data_reg  <= link2_data_next;
        out_reg         <= out_next;
    end

endmodule

### src/olid_store.sv
// Node store: link memory and value memory, one write and one read port each.
// Read data is registered. Depends on olid_pkg.
module olid_store
    import olid_pkg::*;
(
    input  logic                      aclk,
    input  olid_mem_req_t             req,
    output olid_idx_t                 link_rdata,
    output logic signed [VALUE_W-1:0] val_rdata
);

    logic [IDX_W-1:0]   link_mem [CAPACITY];
    logic [VALUE_W-1:0] val_mem  [CAPACITY];

    olid_idx_t          link_rdata_reg;
    logic [VALUE_W-1:0] val_rdata_reg;

    // Link memory: write, then registered read
    always_ff @(posedge aclk) begin
        if (req.link_we) begin
            link_mem[req.link_waddr] <= req.link_wdata;
        end
        link_rdata_reg <= link_mem[req.link_raddr];
    end

    // Value memory: write, then registered read
    always_ff @(posedge aclk) begin
        if (req.val_we) begin
            val_mem[req.val_waddr] <= req.val_wdata;
        end
        val_rdata_reg <= val_mem[req.val_raddr];
    end

    assign link_rdata = link_rdata_reg;
    assign val_rdata  = $signed(val_rdata_reg);

endmodule

### src/olid_checker.sv
// Port-level checks for the ordered list block, bound to the top level.
// Depends on olid_pkg; sees the top-level ports only.
module olid_checker
    import olid_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input olid_in_t  s_payload,
    input logic      m_valid,
    input logic      m_ready,
    input olid_out_t m_payload
);

    // Count never passes the store size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.element_count <= COUNT_W'(CAPACITY)))
        else $error("element count above capacity");

    // Empty list shows zero at both ends
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.element_count == '0)) |->
        ((m_payload.front_value == '0) && (m_payload.back_value == '0)))
        else $error("empty list with nonzero end values");

    // Full refusal only on a full list, empty refusal only on an empty one
    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        ((m_payload.status != STAT_FULL) ||
         (m_payload.element_count == COUNT_W'(CAPACITY))) &&
        ((m_payload.status != STAT_EMPTY) || (m_payload.element_count == '0)))
        else $error("status does not match element count");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("result changed while stalled");

endmodule

bind ordered_list_insert_delete olid_checker u_olid_checker (.*);
